>>> design/hrf_pkg.sv
// shared types, constants and the report size lookup for the hid report fragmenter
package hrf_pkg;

    localparam int LENGTH_BITS = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int FS_N = 5;
    localparam int HS_N = 9;

    localparam logic [7:0] FS_ID   [FS_N] = '{8'h05, 8'h06, 8'h07, 8'h08, 8'h09};
    localparam logic [7:0] FS_SIZE [FS_N] = '{8'h08, 8'h0A, 8'h0E, 8'h14, 8'h3F};
    localparam logic [7:0] HS_ID   [HS_N] = '{8'h0D, 8'h0E, 8'h0F, 8'h10, 8'h11,
                                              8'h12, 8'h13, 8'h14, 8'h15};
    localparam logic [7:0] HS_SIZE [HS_N] = '{8'h05, 8'h09, 8'h0D, 8'h11, 8'h19,
                                              8'h31, 8'h5F, 8'hC1, 8'hFF};

    localparam int LC_CONTINUE = 0;
    localparam int LC_MORE     = 1;

    typedef enum logic [1:0] {
        ROLE_ID   = 2'd0,
        ROLE_LC   = 2'd1,
        ROLE_DATA = 2'd2
    } t_role;

    typedef enum logic [1:0] {
        PH_ID,
        PH_LC,
        PH_DATA
    } t_phase;

    typedef struct packed {
        logic [7:0] id;
        logic [7:0] cap;
    } t_size;

    typedef struct packed {
        logic [7:0] data;
        logic       hdr;
        logic [7:0] id;
        logic [1:0] lc;
        logic [7:0] pad;
        logic       eor;
        logic       eom;
    } t_entry;

    function automatic t_size pick_size(input logic hs, input logic [LENGTH_BITS-1:0] left);
        t_size r;
        if (hs) begin
            r.id  = HS_ID[HS_N-1];
            r.cap = HS_SIZE[HS_N-1] - 8'd1;
            for (int i = HS_N - 1; i >= 0; i--) begin
                if (left < LENGTH_BITS'(HS_SIZE[i])) begin
                    r.id  = HS_ID[i];
                    r.cap = HS_SIZE[i] - 8'd1;
                end
            end
        end else begin
            r.id  = FS_ID[FS_N-1];
            r.cap = FS_SIZE[FS_N-1] - 8'd1;
            for (int i = FS_N - 1; i >= 0; i--) begin
                if (left < LENGTH_BITS'(FS_SIZE[i])) begin
                    r.id  = FS_ID[i];
                    r.cap = FS_SIZE[i] - 8'd1;
                end
            end
        end
        return r;
    endfunction

endpackage

>>> design/hid_report_fragmenter.sv
// top level of the hid report fragmenter
//
// channel     direction  tdata                                   tuser          tlast
// s_axis      in         [7:0] data_byte [23:8] message_length   message_start  -
// m_axis      out        [7:0] out_byte [15:8] pad_after         byte_role      last
//                        [16] end_of_report [17] end_of_message
// cfg         in         i_cfg_wdata = high_speed, written when i_cfg_we is high
//
// each accepted byte yields one data beat, or three beats (id, link control, data) at
// the start of a report, while message bytes remain (other bytes are dropped); a
// four-entry queue separates classification from output
// input stalls only when the queue is full; output stalls hold the beat in its register
// synchronous active-low reset clears framing state, queue and output valid
module hid_report_fragmenter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // data_byte, message_length
    input  logic        s_axis_tuser,   // message_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_byte, pad_after, end_of_report, end_of_message
    output logic [1:0]  m_axis_tuser,   // byte_role
    output logic        m_axis_tlast
);

    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    hrf_pkg::t_entry entry;
    hrf_pkg::t_entry head;
    logic [7:0]      out_byte;
    logic [7:0]      pad_after;
    logic            eor;
    logic            eom;

    hrf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_data_byte      (s_axis_tdata[7:0]),
        .i_message_start  (s_axis_tuser),
        .i_message_length (s_axis_tdata[23:8]),
        .i_full           (full),
        .o_push           (push),
        .o_entry          (entry)
    );

    hrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    hrf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (empty),
        .i_head           (head),
        .o_pop            (pop),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_out_byte       (out_byte),
        .o_byte_role      (m_axis_tuser),
        .o_pad_after      (pad_after),
        .o_end_of_report  (eor),
        .o_end_of_message (eom),
        .o_last           (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, eom, eor, pad_after, out_byte};

endmodule

>>> design/hrf_front.sv
// front end: accepts message bytes, tracks framing state and classifies each byte
module hrf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_message_start,
    input  logic [15:0]           i_message_length,
    input  logic                  i_full,
    output logic                  o_push,
    output hrf_pkg::t_entry       o_entry
);

    logic                            r_high_speed;
    logic [hrf_pkg::LENGTH_BITS-1:0] r_mbl, n_mbl;
    logic [7:0]                      r_rbl, n_rbl;
    logic [7:0]                      r_pad, n_pad;
    logic                            r_first, n_first;
    hrf_pkg::t_size                  sz;
    logic [7:0]                      copy;
    logic                            accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        n_mbl   = r_mbl;
        n_rbl   = r_rbl;
        n_pad   = r_pad;
        n_first = r_first;
        o_push  = 1'b0;
        o_entry = '0;
        sz      = hrf_pkg::pick_size(r_high_speed, r_mbl);
        copy    = '0;
        if (accept) begin
            if (i_message_start) begin
                n_mbl   = hrf_pkg::LENGTH_BITS'(i_message_length);
                n_rbl   = '0;
                n_pad   = '0;
                n_first = 1'b1;
            end
            sz = hrf_pkg::pick_size(r_high_speed, n_mbl);
            if (n_mbl != '0) begin
                o_push       = 1'b1;
                o_entry.data = i_data_byte;
                if (n_rbl == '0) begin
                    copy = (n_mbl < hrf_pkg::LENGTH_BITS'(sz.cap)) ? n_mbl[7:0] : sz.cap;
                    o_entry.hdr                  = 1'b1;
                    o_entry.id                   = sz.id;
                    o_entry.lc[hrf_pkg::LC_CONTINUE] = !n_first;
                    o_entry.lc[hrf_pkg::LC_MORE] =
                        (hrf_pkg::LENGTH_BITS'(copy) != n_mbl);
                    n_rbl   = copy;
                    n_pad   = sz.cap - copy;
                    n_first = 1'b0;
                end
                n_rbl       = n_rbl - 8'd1;
                n_mbl       = n_mbl - hrf_pkg::LENGTH_BITS'(1);
                o_entry.eor = (n_rbl == '0);
                o_entry.eom = (n_mbl == '0);
                o_entry.pad = o_entry.eor ? n_pad : 8'd0;
                if (o_entry.eor) begin
                    n_pad = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_speed <= 1'b1;
            r_mbl        <= '0;
            r_rbl        <= '0;
            r_pad        <= '0;
            r_first      <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_high_speed <= i_cfg_wdata;
            end
            r_mbl   <= n_mbl;
            r_rbl   <= n_rbl;
            r_pad   <= n_pad;
            r_first <= n_first;
        end
    end

endmodule

>>> design/hrf_queue.sv
// short queue of classified bytes between front and back end
module hrf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hrf_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output hrf_pkg::t_entry o_head
);

    hrf_pkg::t_entry                r_mem [hrf_pkg::QUEUE_DEPTH];
    logic [hrf_pkg::QUEUE_AW-1:0]   r_wr;
    logic [hrf_pkg::QUEUE_AW-1:0]   r_rd;
    logic [hrf_pkg::QUEUE_AW:0]     r_cnt;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = (r_cnt == (hrf_pkg::QUEUE_AW + 1)'(hrf_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + hrf_pkg::QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + hrf_pkg::QUEUE_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (hrf_pkg::QUEUE_AW + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (hrf_pkg::QUEUE_AW + 1)'(1);
            end
        end
    end

endmodule

>>> design/hrf_back.sv
// back end: expands queued bytes into id, link control and data beats
module hrf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  hrf_pkg::t_entry i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_byte_role,
    output logic [7:0]      o_pad_after,
    output logic            o_end_of_report,
    output logic            o_end_of_message,
    output logic            o_last
);

    hrf_pkg::t_phase r_phase, n_phase;
    logic            r_valid;
    logic [7:0]      r_byte, n_byte;
    hrf_pkg::t_role  r_role, n_role;
    logic [7:0]      r_pad, n_pad;
    logic            r_eor, n_eor;
    logic            r_eom, n_eom;
    logic            r_last, n_last;
    logic            load;
    logic            emit;

    assign load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hrf_pkg::PH_ID;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_phase = r_phase;
        o_pop   = 1'b0;
        emit    = 1'b0;
        n_byte  = i_head.data;
        n_role  = hrf_pkg::ROLE_DATA;
        n_pad   = i_head.pad;
        n_eor   = i_head.eor;
        n_eom   = i_head.eom;
        n_last  = 1'b1;
        if (load && !i_empty) begin
            emit = 1'b1;
            unique case (r_phase)
                hrf_pkg::PH_ID: begin
                    if (i_head.hdr) begin
                        n_byte  = i_head.id;
                        n_role  = hrf_pkg::ROLE_ID;
                        n_pad   = '0;
                        n_eor   = 1'b0;
                        n_eom   = 1'b0;
                        n_last  = 1'b0;
                        n_phase = hrf_pkg::PH_LC;
                    end else begin
                        o_pop = 1'b1;
                    end
                end
                hrf_pkg::PH_LC: begin
                    n_byte  = {6'd0, i_head.lc};
                    n_role  = hrf_pkg::ROLE_LC;
                    n_pad   = '0;
                    n_eor   = 1'b0;
                    n_eom   = 1'b0;
                    n_last  = 1'b0;
                    n_phase = hrf_pkg::PH_DATA;
                end
                hrf_pkg::PH_DATA: begin
                    o_pop   = 1'b1;
                    n_phase = hrf_pkg::PH_ID;
                end
                default: begin
                    n_phase = hrf_pkg::PH_ID;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= n_byte;
            r_role <= n_role;
            r_pad  <= n_pad;
            r_eor  <= n_eor;
            r_eom  <= n_eom;
            r_last <= n_last;
        end
    end

    assign o_valid          = r_valid;
    assign o_out_byte       = r_byte;
    assign o_byte_role      = r_role;
    assign o_pad_after      = r_pad;
    assign o_end_of_report  = r_eor;
    assign o_end_of_message = r_eom;
    assign o_last           = r_last;

endmodule
